[design/sorted_ring_priority_queue_top_macros.svh]
// assertion macros for the sorted ring priority queue
`ifndef SORTED_RING_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_RING_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SRPQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SRPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/srpq_pkg.sv]
// types and constants shared by the sorted ring priority queue
package srpq_pkg;

	localparam int PRIO_W = 8;
	localparam int TAG_W  = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_PATH,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic              kind;
		logic [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [PRIO_W-1:0] out_priority;
		logic [TAG_W-1:0]  out_tag;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		logic flag_en;
		logic path_en;
		logic apply;
	} fsm_ctrl_t;

	typedef struct packed {
		logic flag_en;
		logic ins_en;
		logic pop_en;
		logic path_tail;
	} cell_ctrl_t;

endpackage

[design/srpq_cell.sv]
// one slot of the sorted chain: holds an entry and its compare flags
module srpq_cell
	import srpq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       valid,
	input  entry_t     new_entry,
	input  entry_t     left_entry,
	input  entry_t     right_entry,
	input  logic       left_before,
	output entry_t     entry,
	output logic       ahead,
	output logic       le
);

	entry_t entry_q;
	logic   lt_q;
	logic   le_q;

	// new entry goes ahead of this slot
	assign ahead = !valid || (ctrl.path_tail ? lt_q : le_q);
	assign entry = entry_q;
	assign le    = le_q;

	always_ff @(posedge clk) begin
		if (ctrl.flag_en) begin
			lt_q <= entry_q.prio <  new_entry.prio;
			le_q <= entry_q.prio <= new_entry.prio;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop_en) begin
			entry_q <= right_entry;
		end else if (ctrl.ins_en) begin
			if (left_before) begin
				entry_q <= left_entry;
			end else if (ahead) begin
				entry_q <= new_entry;
			end
		end
	end

endmodule

[design/srpq_ctrl.sv]
// sequencer for one request: compare, pick path, apply
module srpq_ctrl
	import srpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      out_free,
	output logic      req_stall,
	output fsm_ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CMP;
			end
			S_CMP:   state_d = S_PATH;
			S_PATH:  state_d = S_APPLY;
			S_APPLY: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall    = 1'b1;
		ctrl.flag_en = 1'b0;
		ctrl.path_en = 1'b0;
		ctrl.apply   = 1'b0;
		case (state_q)
			S_IDLE:  req_stall    = 1'b0;
			S_CMP:   ctrl.flag_en = 1'b1;
			S_PATH:  ctrl.path_en = 1'b1;
			S_APPLY: ctrl.apply   = out_free;
			default: req_stall    = 1'b1;
		endcase
	end

endmodule

[design/sorted_ring_priority_queue_top.sv]
// sorted priority queue top level: chain of entry cells, sequencer, result register
//
// usage
//  request channel req_valid/req_stall/req_item: insert (priority, tag) or pop.
//  response channel rsp_valid/rsp_stall/rsp_item: one result per request with
//  status inserted, full, popped or empty; popped priority and tag, else zero.
//  cfg_we/cfg_wdata set the capacity (0 acts as 1, above DEPTH as DEPTH) and
//  empty the queue; write only while the block is idle.
//  entries sit in a row of DEPTH cells sorted highest priority first; an insert
//  shifts the lower part one cell toward the tail, a pop shifts all toward head.
//  timing: a request is taken only when the sequencer is idle; rsp_valid rises
//  after the sequencer's three steps (compare, middle select, apply), and no new
//  request is taken until the last one has been through them.
//  the result register lets the next request in while a result waits; a
//  stalled receiver holds the apply step, and so the request after it.
//  reset: queue empty, capacity 16, no result pending. cell contents are not
//  cleared and are never read before written.
`include "sorted_ring_priority_queue_top_macros.svh"

module sorted_ring_priority_queue_top
	import srpq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req_item,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp_item
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int XW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [XW-1:0]    cap_x;
	logic [XW-1:0]    eff_x;
	logic [CW-1:0]    eff_cap;
	req_t             req_q;
	logic             path_tail_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	status_t          status;
	logic             full;
	logic             empty;
	logic             out_free;
	fsm_ctrl_t        fsm;
	cell_ctrl_t       cell_ctrl;
	entry_t           new_e;
	entry_t           entries [DEPTH];
	logic [DEPTH-1:0] le_vec;
	logic [DEPTH-1:0] before_vec;
	logic [AW-1:0]    mid_idx;

	// effective capacity
	assign cap_x   = XW'(cap_q);
	assign eff_x   = (cap_x == '0) ? XW'(1) : ((cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x);
	assign eff_cap = CW'(eff_x);
	assign full    = count_q >= eff_cap;
	assign empty   = count_q == '0;
	assign mid_idx = AW'(count_q >> 1);

	assign out_free = !rsp_valid_q || !rsp_stall;

	srpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.out_free  (out_free),
		.req_stall (req_stall),
		.ctrl      (fsm)
	);

	assign new_e.prio = req_q.priority_req;
	assign new_e.tag  = req_q.tag;

	always_comb begin
		if (req_q.kind == KIND_INSERT) begin
			status = full ? ST_FULL : ST_INSERTED;
		end else begin
			status = empty ? ST_EMPTY : ST_POPPED;
		end
	end

	assign cell_ctrl.flag_en   = fsm.flag_en;
	assign cell_ctrl.ins_en    = fsm.apply && (status == ST_INSERTED);
	assign cell_ctrl.pop_en    = fsm.apply && (status == ST_POPPED);
	assign cell_ctrl.path_tail = path_tail_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_b;

		if (i == 0) begin : g_head
			assign left_e = new_e;
			assign left_b = 1'b0;
		end else begin : g_body
			assign left_e = entries[i-1];
			assign left_b = before_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = entries[i];
		end else begin : g_inner
			assign right_e = entries[i+1];
		end

		srpq_cell u_cell (
			.clk         (clk),
			.ctrl        (cell_ctrl),
			.valid       (CW'(i) < count_q),
			.new_entry   (new_e),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_before (left_b),
			.entry       (entries[i]),
			.ahead       (before_vec[i]),
			.le          (le_vec[i])
		);
	end

	// request capture and tail/head path choice
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_q <= req_item;
		end
		if (fsm.path_en) begin
			path_tail_q <= !le_vec[mid_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
		end else if (cfg_we) begin
			cap_q   <= cfg_wdata;
			count_q <= '0;
		end else if (cell_ctrl.ins_en) begin
			count_q <= count_q + CW'(1);
		end else if (cell_ctrl.pop_en) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_comb begin
		rsp_d.status       = status;
		rsp_d.out_priority = (status == ST_POPPED) ? entries[0].prio : '0;
		rsp_d.out_tag      = (status == ST_POPPED) ? entries[0].tag : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fsm.apply) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fsm.apply) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	`SRPQ_ASSERT_SAME(a_count_in_cap, 1'b1, count_q <= eff_cap, "entry count above capacity")
	`SRPQ_ASSERT_NEXT(a_pop_dec, cell_ctrl.pop_en, count_q == $past(count_q) - CW'(1), "pop did not remove an entry")
	`SRPQ_ASSERT_SAME(a_head_sorted, (count_q >= CW'(2)) && !fsm.apply, entries[0].prio >= entries[1].prio, "head entry out of order")

endmodule
